>>> design/keyed_watchdog_timer_macros.svh
// assertion macros for the keyed watchdog timer checker
// expects clk and rst_n in the scope where a macro is used
`ifndef KEYED_WATCHDOG_TIMER_MACROS_SVH
`define KEYED_WATCHDOG_TIMER_MACROS_SVH

// property that holds in the same cycle
`define KWDT_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// property that holds in the next cycle
`define KWDT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/kwdt_pkg.sv
// shared types and constants for the keyed watchdog timer
// used by keyed_watchdog_timer, kwdt_checker and the testbench; no dependencies
package kwdt_pkg;

  localparam int unsigned PRESCALE_DIVIDE = 256;
  localparam int unsigned PRESC_W = (PRESCALE_DIVIDE > 2) ? $clog2(PRESCALE_DIVIDE) : 1;

  localparam int unsigned ADDR_W = 16;
  localparam int unsigned DATA_W = 32;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  localparam logic [ADDR_W-1:0] ADDR_CS  = 16'h0000;
  localparam logic [ADDR_W-1:0] ADDR_CNT = 16'h0004;
  localparam logic [ADDR_W-1:0] ADDR_TOV = 16'h0008;
  localparam logic [ADDR_W-1:0] ADDR_WIN = 16'h000C;

  localparam logic [DATA_W-1:0] KEY_UNLOCK  = 32'hD928C520;
  localparam logic [DATA_W-1:0] KEY_REFRESH = 32'hB480A602;

  localparam logic [DATA_W-1:0] BIT_EN      = 32'h00000080;
  localparam logic [DATA_W-1:0] BIT_RCS     = 32'h00000400;
  localparam logic [DATA_W-1:0] BIT_ULK     = 32'h00000800;
  localparam logic [DATA_W-1:0] BIT_PRES    = 32'h00001000;
  localparam logic [DATA_W-1:0] BIT_CMD32EN = 32'h00002000;

endpackage

>>> design/keyed_watchdog_timer.sv
// keyed watchdog timer: one bus read, bus write or clock tick per word
// a result word is registered into the output register when its input word is taken
// throughput: one word per cycle while the output is not stalled; the output register is the only stage
// reset (rst_n low, synchronous): registers to power-on values, output empty
// depends on kwdt_pkg
module keyed_watchdog_timer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,   // functional_mode
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,      // address[15:0], write_data[47:16]
  input  logic [1:0]  in_tuser,      // op[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,     // read_data[31:0]
  output logic [1:0]  out_tuser      // bad_access[0], bite[1]
);

  localparam int unsigned PW = kwdt_pkg::PRESC_W;

  logic                        func_mode_r;
  logic [kwdt_pkg::DATA_W-1:0] cs_r, cs_nxt;
  logic [kwdt_pkg::DATA_W-1:0] tov_r, tov_nxt;
  logic [kwdt_pkg::DATA_W-1:0] win_r, win_nxt;
  logic                        ulk_r, ulk_nxt;
  logic                        rcs_r, rcs_nxt;
  logic                        run_r, run_nxt;
  logic [kwdt_pkg::DATA_W-1:0] remain_r, remain_nxt;
  logic [PW-1:0]               presc_r, presc_nxt;

  logic                        out_valid_r;
  logic [kwdt_pkg::DATA_W-1:0] rd_r, rd_nxt;
  logic                        bad_r, bad_nxt;
  logic                        bite_r, bite_nxt;

  logic                        accept;
  logic [kwdt_pkg::ADDR_W-1:0] addr;
  logic [kwdt_pkg::DATA_W-1:0] wdata;
  logic                        do_arm;
  logic                        arm_ok;
  logic                        count_done;
  logic [kwdt_pkg::DATA_W-1:0] remain_dec;

  assign in_tready = ~out_valid_r | out_tready;
  assign accept    = in_tvalid & in_tready;
  assign addr      = in_tdata[15:0];
  assign wdata     = in_tdata[47:16];

  assign out_tvalid = out_valid_r;
  assign out_tdata  = rd_r;
  assign out_tuser  = {bite_r, bad_r};

  always_comb begin
    cs_nxt     = cs_r;
    tov_nxt    = tov_r;
    win_nxt    = win_r;
    ulk_nxt    = ulk_r;
    rcs_nxt    = rcs_r;
    run_nxt    = run_r;
    remain_nxt = remain_r;
    presc_nxt  = presc_r;
    rd_nxt     = '0;
    bad_nxt    = 1'b0;
    bite_nxt   = 1'b0;
    do_arm     = 1'b0;
    count_done = 1'b1;
    remain_dec = remain_r;

    case (in_tuser)
      kwdt_pkg::OP_READ: begin
        case (addr)
          kwdt_pkg::ADDR_CS: begin
            rd_nxt = cs_r | (ulk_r ? kwdt_pkg::BIT_ULK : '0) |
                     (rcs_r ? kwdt_pkg::BIT_RCS : '0);
          end
          kwdt_pkg::ADDR_CNT: rd_nxt = '0;
          kwdt_pkg::ADDR_TOV: rd_nxt = tov_r;
          kwdt_pkg::ADDR_WIN: rd_nxt = win_r;
          default:            bad_nxt = 1'b1;
        endcase
      end
      kwdt_pkg::OP_WRITE: begin
        case (addr)
          kwdt_pkg::ADDR_CS: begin
            if (ulk_r) begin
              cs_nxt  = wdata & ~(kwdt_pkg::BIT_ULK | kwdt_pkg::BIT_RCS);
              ulk_nxt = 1'b0;
              rcs_nxt = 1'b1;
              do_arm  = 1'b1;
            end
          end
          kwdt_pkg::ADDR_CNT: begin
            if (wdata == kwdt_pkg::KEY_UNLOCK) begin
              ulk_nxt = 1'b1;
              rcs_nxt = 1'b0;
            end else if (wdata == kwdt_pkg::KEY_REFRESH) begin
              do_arm = 1'b1;
            end
          end
          kwdt_pkg::ADDR_TOV: if (ulk_r) tov_nxt = wdata;
          kwdt_pkg::ADDR_WIN: if (ulk_r) win_nxt = wdata;
          default:            bad_nxt = 1'b1;
        endcase
      end
      kwdt_pkg::OP_TICK: begin
        if (run_r) begin
          if ((cs_r & kwdt_pkg::BIT_PRES) != '0) begin
            if (presc_r >= PW'(kwdt_pkg::PRESCALE_DIVIDE - 1)) begin
              presc_nxt = '0;
            end else begin
              presc_nxt  = presc_r + PW'(1);
              count_done = 1'b0;
            end
          end
          if (count_done) begin
            if (remain_r != '0) remain_dec = remain_r - 32'd1;
            remain_nxt = remain_dec;
            if (remain_dec == '0) begin
              bite_nxt  = 1'b1;
              run_nxt   = 1'b0;
              presc_nxt = '0;
            end
          end
        end
      end
      default: ;
    endcase

    // arming sees the freshly written control/status
    arm_ok = func_mode_r & ((cs_nxt & kwdt_pkg::BIT_EN) != '0) & (tov_r != '0);
    if (do_arm) begin
      run_nxt    = arm_ok;
      remain_nxt = arm_ok ? tov_r : '0;
      presc_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      func_mode_r <= 1'b0;
      cs_r        <= kwdt_pkg::BIT_CMD32EN;
      tov_r       <= '0;
      win_r       <= '0;
      ulk_r       <= 1'b0;
      rcs_r       <= 1'b0;
      run_r       <= 1'b0;
      remain_r    <= '0;
      presc_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) func_mode_r <= cfg_wr_data;
      if (accept) begin
        cs_r     <= cs_nxt;
        tov_r    <= tov_nxt;
        win_r    <= win_nxt;
        ulk_r    <= ulk_nxt;
        rcs_r    <= rcs_nxt;
        run_r    <= run_nxt;
        remain_r <= remain_nxt;
        presc_r  <= presc_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r   <= rd_nxt;
      bad_r  <= bad_nxt;
      bite_r <= bite_nxt;
    end
  end

endmodule

>>> design/kwdt_checker.sv
// port-level checks for keyed_watchdog_timer, attached by bind
// depends on kwdt_pkg and keyed_watchdog_timer_macros.svh
`include "keyed_watchdog_timer_macros.svh"

module kwdt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [47:0] in_tdata,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser
);

  `KWDT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata),
    "stalled output word changed")
  `KWDT_ASSERT(a_flags_excl, out_tvalid, !(out_tuser[0] && out_tuser[1]),
    "bite and bad access in one word")
  `KWDT_ASSERT(a_bite_no_data, out_tvalid && out_tuser[1], out_tdata == 32'd0,
    "bite word carries read data")
  `KWDT_ASSERT_NEXT(a_cnt_read_zero,
    in_tvalid && in_tready && in_tuser == kwdt_pkg::OP_READ &&
    in_tdata[15:0] == kwdt_pkg::ADDR_CNT,
    out_tvalid && out_tdata == 32'd0 && out_tuser == 2'b00,
    "counter read did not return zero next cycle")

endmodule

bind keyed_watchdog_timer kwdt_checker u_kwdt_checker (.*);

>>> bench/tb_keyed_watchdog_timer.sv
// testbench for keyed_watchdog_timer: a queued stream driver, a monitor that predicts
// each result word from its own copy of the watchdog registers, and a stall watchdog
// depends on kwdt_pkg and keyed_watchdog_timer
module tb_keyed_watchdog_timer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CLK_HALF = 2;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 4000;
  localparam int PHASE_WORDS = 470;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] addr;
    logic [31:0] data;
  } wd_access_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic        bad;
    logic        bite;
  } wd_reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;

  keyed_watchdog_timer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #(CLK_HALF) clk = ~clk;

  // predicted watchdog state
  logic        wd_mode;
  logic [31:0] wd_cs;
  logic [31:0] wd_timeout;
  logic [31:0] wd_window;
  logic        wd_open;
  logic        wd_rcs;
  logic        wd_armed;
  logic [31:0] wd_left;
  int unsigned wd_presc;

  wd_access_t access_q[$];
  wd_reply_t  reply_q[$];
  int         words_queued = 0;
  int         fail_cnt = 0;
  int         quiet_cycles = 0;
  bit         in_taken = 1'b0;
  int         hold_req = 0;
  int         hold_ack = 0;

  function automatic void wd_rearm();
    wd_presc = 0;
    if (!wd_mode || (wd_cs & kwdt_pkg::BIT_EN) == '0 || wd_timeout == '0) begin
      wd_armed = 1'b0;
      wd_left  = '0;
    end else begin
      wd_armed = 1'b1;
      wd_left  = wd_timeout;
    end
  endfunction

  function automatic wd_reply_t wd_step(wd_access_t a);
    wd_reply_t r;
    bit        count_done;
    r = '0;
    case (a.op)
      kwdt_pkg::OP_READ: begin
        case (a.addr)
          kwdt_pkg::ADDR_CS: begin
            r.rdata = wd_cs | (wd_open ? kwdt_pkg::BIT_ULK : '0) |
                      (wd_rcs ? kwdt_pkg::BIT_RCS : '0);
          end
          kwdt_pkg::ADDR_CNT: r.rdata = '0;
          kwdt_pkg::ADDR_TOV: r.rdata = wd_timeout;
          kwdt_pkg::ADDR_WIN: r.rdata = wd_window;
          default:            r.bad = 1'b1;
        endcase
      end
      kwdt_pkg::OP_WRITE: begin
        case (a.addr)
          kwdt_pkg::ADDR_CS: begin
            if (wd_open) begin
              wd_cs   = a.data & ~(kwdt_pkg::BIT_ULK | kwdt_pkg::BIT_RCS);
              wd_open = 1'b0;
              wd_rcs  = 1'b1;
              wd_rearm();
            end
          end
          kwdt_pkg::ADDR_CNT: begin
            if (a.data == kwdt_pkg::KEY_UNLOCK) begin
              wd_open = 1'b1;
              wd_rcs  = 1'b0;
            end else if (a.data == kwdt_pkg::KEY_REFRESH) begin
              wd_rearm();
            end
          end
          kwdt_pkg::ADDR_TOV: if (wd_open) wd_timeout = a.data;
          kwdt_pkg::ADDR_WIN: if (wd_open) wd_window = a.data;
          default:            r.bad = 1'b1;
        endcase
      end
      kwdt_pkg::OP_TICK: begin
        if (wd_armed) begin
          count_done = 1'b1;
          if ((wd_cs & kwdt_pkg::BIT_PRES) != '0) begin
            if (wd_presc >= kwdt_pkg::PRESCALE_DIVIDE - 1) begin
              wd_presc = 0;
            end else begin
              wd_presc   = (wd_presc + 1) & 32'hFF;
              count_done = 1'b0;
            end
          end
          if (count_done) begin
            if (wd_left != '0) wd_left = wd_left - 1;
            if (wd_left == '0) begin
              r.bite   = 1'b1;
              wd_armed = 1'b0;
              wd_presc = 0;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (fail_cnt < 100)
      $display("%0t ns %s: got %h want %h", $realtime, what, got, want);
    fail_cnt++;
  endtask

  // monitor: predicts on accepted input words, checks accepted result words
  always @(posedge clk) begin : monitor
    wd_access_t a;
    wd_reply_t  got;
    wd_reply_t  want;
    in_taken = 1'b0;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.rdata = out_tdata;
        got.bad   = out_tuser[0];
        got.bite  = out_tuser[1];
        if (reply_q.size() == 0) begin
          note_mismatch("result word with nothing pending", got.rdata, '0);
        end else begin
          want = reply_q.pop_front();
          if (got.rdata !== want.rdata) note_mismatch("read_data", got.rdata, want.rdata);
          if (got.bad !== want.bad)
            note_mismatch("bad_access", 32'(got.bad), 32'(want.bad));
          if (got.bite !== want.bite)
            note_mismatch("bite", 32'(got.bite), 32'(want.bite));
        end
      end
      if (in_tvalid && in_tready) begin
        in_taken = 1'b1;
        a.op   = in_tuser;
        a.addr = in_tdata[15:0];
        a.data = in_tdata[47:16];
        reply_q.push_back(wd_step(a));
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("keyed_watchdog_timer: mismatch");
        $finish;
      end
    end
  end

  // sender: bursts of random length with random gaps
  int tx_burst = 0;
  int tx_gap = 0;

  always @(negedge clk) begin : driver
    wd_access_t a;
    if (!in_tvalid || in_taken) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_tvalid <= 1'b0;
      end else if (access_q.size() == 0) begin
        in_tvalid <= 1'b0;
      end else begin
        a = access_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {a.data, a.addr};
        in_tuser  <= a.op;
        if (tx_burst > 0) tx_burst--;
        if (tx_burst == 0) begin
          if ($urandom_range(0, 7) == 0) begin
            tx_burst = $urandom_range(100, 250);
            tx_gap   = 0;
          end else begin
            tx_burst = $urandom_range(1, 24);
            tx_gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
    end
  end

  // receiver: changing stall patterns plus requested long hold-offs
  int rx_mode = 0;
  int rx_mode_left = 0;
  int rx_cnt = 0;
  int rx_hold_left = 0;

  always @(negedge clk) begin : receiver
    bit rdy;
    rx_cnt++;
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      rdy = 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack++;
      rx_hold_left = HOLD_CYCLES;
      rdy = 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 2);
        rx_mode_left = $urandom_range(32, 200);
      end
      rx_mode_left--;
      case (rx_mode)
        0:       rdy = 1'b1;
        1:       rdy = ($urandom_range(0, 3) != 0);
        default: rdy = ((rx_cnt % 5) < 3);
      endcase
    end
    out_tready <= rdy;
  end

  task automatic push_word(logic [1:0] op, logic [15:0] addr, logic [31:0] data);
    wd_access_t a;
    a.op   = op;
    a.addr = addr;
    a.data = data;
    access_q.push_back(a);
    words_queued++;
  endtask

  task automatic rd(logic [15:0] addr);
    push_word(kwdt_pkg::OP_READ, addr, $urandom);
  endtask

  task automatic wr(logic [15:0] addr, logic [31:0] data);
    push_word(kwdt_pkg::OP_WRITE, addr, data);
  endtask

  function automatic logic [15:0] pick_reg();
    case ($urandom_range(0, 3))
      0:       return kwdt_pkg::ADDR_CS;
      1:       return kwdt_pkg::ADDR_CNT;
      2:       return kwdt_pkg::ADDR_TOV;
      default: return kwdt_pkg::ADDR_WIN;
    endcase
  endfunction

  // ticks, optionally mixed with reads and refreshes
  task automatic tick_run(int n, bit busy);
    for (int i = 0; i < n; i++) begin
      if (busy && $urandom_range(0, 7) == 0) rd(pick_reg());
      if (busy && $urandom_range(0, 23) == 0) wr(kwdt_pkg::ADDR_CNT, kwdt_pkg::KEY_REFRESH);
      push_word(kwdt_pkg::OP_TICK, 16'($urandom_range(0, 65535)), $urandom);
    end
  endtask

  task automatic arm_session();
    logic [31:0] tov;
    logic [31:0] cs;
    bit          pres;
    int          n;
    pres = ($urandom_range(0, 39) == 0);
    case ($urandom_range(0, 9))
      0:       tov = '0;
      1:       tov = $urandom;
      default: tov = $urandom_range(1, 12);
    endcase
    if (pres) tov = 32'd1;
    cs = $urandom;
    if ($urandom_range(0, 4) != 0) cs = cs | kwdt_pkg::BIT_EN;
    cs = pres ? (cs | kwdt_pkg::BIT_PRES) : (cs & ~kwdt_pkg::BIT_PRES);
    wr(kwdt_pkg::ADDR_CNT, kwdt_pkg::KEY_UNLOCK);
    if ($urandom_range(0, 1) == 0) rd(kwdt_pkg::ADDR_CS);
    wr(kwdt_pkg::ADDR_TOV, tov);
    if ($urandom_range(0, 2) == 0) wr(kwdt_pkg::ADDR_WIN, $urandom);
    if ($urandom_range(0, 3) == 0) rd(pick_reg());
    wr(kwdt_pkg::ADDR_CS, cs);
    n = (tov > 16) ? 4 : int'(tov);
    if (pres) n = n * kwdt_pkg::PRESCALE_DIVIDE;
    tick_run(n + $urandom_range(0, 3), !pres);
  endtask

  task automatic noise_session();
    logic [1:0]  op;
    logic [15:0] addr;
    logic [31:0] data;
    repeat ($urandom_range(1, 8)) begin
      op   = ($urandom_range(0, 9) == 0) ? OP_UNUSED : 2'($urandom_range(0, 2));
      addr = ($urandom_range(0, 1) == 0) ? pick_reg() : 16'($urandom_range(0, 65535));
      case ($urandom_range(0, 5))
        0:       data = kwdt_pkg::KEY_UNLOCK;
        1:       data = kwdt_pkg::KEY_REFRESH;
        default: data = $urandom;
      endcase
      push_word(op, addr, data);
    end
  endtask

  task automatic drain();
    while (access_q.size() != 0 || in_tvalid || reply_q.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic load_mode(logic mode);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    wd_mode = mode;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_phase(logic mode, bit hold);
    int stop_at;
    drain();
    load_mode(mode);
    if (hold) hold_req++;
    stop_at = words_queued + PHASE_WORDS;
    while (words_queued < stop_at) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: arm_session();
        11, 12, 13, 14: begin
          wr(kwdt_pkg::ADDR_CNT, kwdt_pkg::KEY_REFRESH);
          tick_run($urandom_range(1, 14), 1'b1);
        end
        default: noise_session();
      endcase
    end
  endtask

  initial begin
    wd_mode    = 1'b0;
    wd_cs      = kwdt_pkg::BIT_CMD32EN;
    wd_timeout = '0;
    wd_window  = '0;
    wd_open    = 1'b0;
    wd_rcs     = 1'b0;
    wd_armed   = 1'b0;
    wd_left    = '0;
    wd_presc   = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    load_mode(1'b1);

    rd(kwdt_pkg::ADDR_CS);
    rd(kwdt_pkg::ADDR_CNT);
    rd(kwdt_pkg::ADDR_TOV);
    rd(kwdt_pkg::ADDR_WIN);
    rd(16'hFFFF);
    wr(16'h0002, 32'hFFFFFFFF);
    wr(kwdt_pkg::ADDR_CS, 32'hFFFFFFFF);
    wr(kwdt_pkg::ADDR_CNT, 32'h12345678);
    wr(kwdt_pkg::ADDR_TOV, 32'd5);
    wr(kwdt_pkg::ADDR_CNT, kwdt_pkg::KEY_UNLOCK);
    rd(kwdt_pkg::ADDR_CS);
    wr(kwdt_pkg::ADDR_TOV, 32'd2);
    wr(kwdt_pkg::ADDR_WIN, 32'hFFFFFFFF);
    rd(kwdt_pkg::ADDR_WIN);
    wr(kwdt_pkg::ADDR_CS, kwdt_pkg::BIT_EN | kwdt_pkg::BIT_ULK | kwdt_pkg::BIT_RCS |
                          kwdt_pkg::BIT_CMD32EN);
    rd(kwdt_pkg::ADDR_CS);
    tick_run(3, 1'b0);
    wr(kwdt_pkg::ADDR_CNT, kwdt_pkg::KEY_REFRESH);
    tick_run(1, 1'b0);
    wr(kwdt_pkg::ADDR_CNT, kwdt_pkg::KEY_REFRESH);
    tick_run(2, 1'b0);
    push_word(OP_UNUSED, 16'hFFFF, 32'hFFFFFFFF);
    push_word(kwdt_pkg::OP_TICK, 16'hFFFF, 32'hFFFFFFFF);
    // unlock clears reconfig-done, then leave a timer running into the mode change
    wr(kwdt_pkg::ADDR_CNT, kwdt_pkg::KEY_UNLOCK);
    rd(kwdt_pkg::ADDR_CS);
    wr(kwdt_pkg::ADDR_TOV, 32'd30);
    wr(kwdt_pkg::ADDR_CS, kwdt_pkg::BIT_EN);
    drain();
    load_mode(1'b0);
    tick_run(32, 1'b0);
    wr(kwdt_pkg::ADDR_CNT, kwdt_pkg::KEY_REFRESH);
    tick_run(2, 1'b0);

    run_phase(1'b0, 1'b1);
    run_phase(1'b1, 1'b0);
    run_phase(1'b0, 1'b0);
    run_phase(1'b1, 1'b1);
    drain();
    repeat (8) @(posedge clk);
    if (fail_cnt == 0)
      $display("keyed_watchdog_timer: match");
    else
      $display("keyed_watchdog_timer: mismatch");
    $finish;
  end

endmodule
